FILE: hw/rtl/gced_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gced_pkg;

    // Stream widths
    localparam int ACT_W      = 2;
    localparam int WORD_W     = 6;
    localparam int DATA_W     = 32;
    localparam int OUT_W      = 54;
    localparam int S_TUSER_W  = ACT_W;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 256;

    // Action codes carried in s_tuser
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

    // Register word map (byte address / 4)
    localparam logic [WORD_W-1:0] W_FSEL_FIRST = 6'd0;
    localparam logic [WORD_W-1:0] W_FSEL_LAST  = 6'd6;
    localparam logic [WORD_W-1:0] W_SET        = 6'd7;
    localparam logic [WORD_W-1:0] W_CLR        = 6'd10;
    localparam logic [WORD_W-1:0] W_LEV        = 6'd13;
    localparam logic [WORD_W-1:0] W_EDS        = 6'd16;
    localparam logic [WORD_W-1:0] W_REN        = 6'd19;
    localparam logic [WORD_W-1:0] W_FEN        = 6'd22;
    localparam logic [WORD_W-1:0] W_HEN        = 6'd25;
    localparam logic [WORD_W-1:0] W_LEN        = 6'd28;
    localparam logic [WORD_W-1:0] W_PUD        = 6'd37;
    localparam logic [WORD_W-1:0] W_PCLK       = 6'd38;

    // Function select layout
    localparam int FSEL_W        = 3;
    localparam int FSEL_PER_WORD = 10;
    localparam int FSEL_WORDS    = 7;
    localparam int FSEL_WORD_W   = FSEL_W * FSEL_PER_WORD;
    localparam int FSEL_IDX_W    = 3;
    localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'd1;

    // Pull codes
    localparam int PULL_W = 2;
    localparam logic [PULL_W-1:0] PULL_DOWN = 2'd1;
    localparam logic [PULL_W-1:0] PULL_UP   = 2'd2;

    typedef enum logic [3:0] {
        REG_NONE,
        REG_FSEL,
        REG_SET,
        REG_CLR,
        REG_LEV,
        REG_EDS,
        REG_REN,
        REG_FEN,
        REG_HEN,
        REG_LEN,
        REG_PUD,
        REG_PCLK
    } reg_kind_t;

    typedef struct packed {
        reg_kind_t kind;
        logic      hi;     // upper pin half of a register pair
    } word_dec_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] word_index;
        logic [DATA_W-1:0] write_data;
        logic [OUT_W-1:0]  pin_levels;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [OUT_W-1:0]  drive_levels;
        logic [OUT_W-1:0]  drive_enables;
        logic [OUT_W-1:0]  pull_up_mask;
        logic [OUT_W-1:0]  pull_down_mask;
        logic              event_pending;
    } res_t;

    // Address decoder for the register word map
    function automatic word_dec_t decode_word(logic [WORD_W-1:0] w);
        word_dec_t d;
        d.kind = REG_NONE;
        d.hi   = 1'b0;
        unique case (w) inside
            [W_FSEL_FIRST:W_FSEL_LAST]: d.kind = REG_FSEL;
            W_PUD:                      d.kind = REG_PUD;
            W_SET,  W_SET  + 6'd1: begin d.kind = REG_SET;  d.hi = (w != W_SET);  end
            W_CLR,  W_CLR  + 6'd1: begin d.kind = REG_CLR;  d.hi = (w != W_CLR);  end
            W_LEV,  W_LEV  + 6'd1: begin d.kind = REG_LEV;  d.hi = (w != W_LEV);  end
            W_EDS,  W_EDS  + 6'd1: begin d.kind = REG_EDS;  d.hi = (w != W_EDS);  end
            W_REN,  W_REN  + 6'd1: begin d.kind = REG_REN;  d.hi = (w != W_REN);  end
            W_FEN,  W_FEN  + 6'd1: begin d.kind = REG_FEN;  d.hi = (w != W_FEN);  end
            W_HEN,  W_HEN  + 6'd1: begin d.kind = REG_HEN;  d.hi = (w != W_HEN);  end
            W_LEN,  W_LEN  + 6'd1: begin d.kind = REG_LEN;  d.hi = (w != W_LEN);  end
            W_PCLK, W_PCLK + 6'd1: begin d.kind = REG_PCLK; d.hi = (w != W_PCLK); end
            default: ;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gced_regfile.sv
`timescale 1ns / 1ps
`default_nettype none

module gced_regfile #(
    parameter int NUM_PINS = 54
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  gced_pkg::cmd_t     cmd,
    output gced_pkg::res_t     result
);
    import gced_pkg::*;

    localparam int FSEL_BITS = NUM_PINS * FSEL_W;
    localparam int FSEL_SPAN = FSEL_WORDS * FSEL_WORD_W;
    localparam int PULL_BITS = NUM_PINS * PULL_W;

    // State
    logic [FSEL_BITS-1:0] fsel_reg,   fsel_next;
    logic [NUM_PINS-1:0]  latch_reg,  latch_next;
    logic [NUM_PINS-1:0]  status_reg, status_next;
    logic [NUM_PINS-1:0]  ren_reg,    ren_next;
    logic [NUM_PINS-1:0]  fen_reg,    fen_next;
    logic [NUM_PINS-1:0]  hen_reg,    hen_next;
    logic [NUM_PINS-1:0]  len_reg,    len_next;
    logic [NUM_PINS-1:0]  prev_reg,   prev_next;
    logic [PULL_W-1:0]    pud_reg,    pud_next;
    logic [PULL_BITS-1:0] pull_reg,   pull_next;

    word_dec_t            dec;
    logic [63:0]          wvec64;
    logic [63:0]          hmask64;
    logic [63:0]          lev64;
    logic [NUM_PINS-1:0]  wvec;
    logic [NUM_PINS-1:0]  hmask;
    logic [NUM_PINS-1:0]  now;
    logic [NUM_PINS-1:0]  ev;
    logic [NUM_PINS-1:0]  en;
    logic [NUM_PINS-1:0]  up;
    logic [NUM_PINS-1:0]  dn;
    logic [FSEL_SPAN-1:0] fsel_ext;
    logic [FSEL_WORD_W-1:0] fsel_words [FSEL_WORDS];
    logic [FSEL_W-1:0]    fsel_field [NUM_PINS];
    logic [NUM_PINS-1:0]  fsel_hit;
    logic [DATA_W-1:0]    rd;
    logic                 wr_en;

    // One pin half of a pin vector as a bus word
    function automatic logic [DATA_W-1:0] half_of(logic [NUM_PINS-1:0] v, logic hi);
        logic [63:0] e;
        e = 64'(v);
        return hi ? e[63:32] : e[31:0];
    endfunction

    // Pin vector to the fixed result width
    function automatic logic [OUT_W-1:0] to_out(logic [NUM_PINS-1:0] v);
        logic [63:0] e;
        e = 64'(v);
        return e[OUT_W-1:0];
    endfunction

    // Per-pin function select write fields and read words
    assign fsel_ext = FSEL_SPAN'(fsel_reg);

    for (genvar p = 0; p < NUM_PINS; p++) begin : g_fsel_pin
        assign fsel_hit[p]   = (cmd.word_index == WORD_W'(p / FSEL_PER_WORD));
        assign fsel_field[p] = cmd.write_data[FSEL_W * (p % FSEL_PER_WORD) +: FSEL_W];
    end

    for (genvar w = 0; w < FSEL_WORDS; w++) begin : g_fsel_word
        assign fsel_words[w] = fsel_ext[w * FSEL_WORD_W +: FSEL_WORD_W];
    end

    // Operand shaping
    always_comb begin
        dec     = decode_word(cmd.word_index);
        wvec64  = dec.hi ? {cmd.write_data, 32'h0} : {32'h0, cmd.write_data};
        hmask64 = dec.hi ? {32'hFFFF_FFFF, 32'h0} : {32'h0, 32'hFFFF_FFFF};
        lev64   = 64'(cmd.pin_levels);
        wvec    = wvec64[NUM_PINS-1:0];
        hmask   = hmask64[NUM_PINS-1:0];
        now     = lev64[NUM_PINS-1:0];
        ev      = (ren_reg & ~prev_reg & now) | (fen_reg & prev_reg & ~now)
                | (hen_reg & now) | (len_reg & ~now);
        wr_en   = (cmd.action == ACT_WRITE);
    end

    // Next state
    always_comb begin
        fsel_next   = fsel_reg;
        latch_next  = latch_reg;
        status_next = status_reg;
        ren_next    = ren_reg;
        fen_next    = fen_reg;
        hen_next    = hen_reg;
        len_next    = len_reg;
        prev_next   = prev_reg;
        pud_next    = pud_reg;
        pull_next   = pull_reg;

        unique case (cmd.action)
            ACT_WRITE: begin
                unique case (dec.kind)
                    REG_SET: latch_next  = latch_reg | wvec;
                    REG_CLR: latch_next  = latch_reg & ~wvec;
                    REG_EDS: status_next = status_reg & ~wvec;
                    REG_REN: ren_next    = (ren_reg & ~hmask) | wvec;
                    REG_FEN: fen_next    = (fen_reg & ~hmask) | wvec;
                    REG_HEN: hen_next    = (hen_reg & ~hmask) | wvec;
                    REG_LEN: len_next    = (len_reg & ~hmask) | wvec;
                    REG_PUD: pud_next    = cmd.write_data[PULL_W-1:0];
                    default: ;
                endcase
            end
            ACT_TICK: begin
                status_next = status_reg | ev;
                prev_next   = now;
            end
            default: ;
        endcase

        // Per-pin function select and pull latching
        for (int p = 0; p < NUM_PINS; p++) begin
            if (wr_en && dec.kind == REG_FSEL && fsel_hit[p]) begin
                fsel_next[p * FSEL_W +: FSEL_W] = fsel_field[p];
            end
            if (wr_en && dec.kind == REG_PCLK && wvec[p]) begin
                pull_next[p * PULL_W +: PULL_W] = pud_reg;
            end
        end
    end

    // Read mux
    always_comb begin
        rd = '0;
        if (cmd.action == ACT_READ) begin
            unique case (dec.kind)
                REG_FSEL: rd = DATA_W'(fsel_words[cmd.word_index[FSEL_IDX_W-1:0]]);
                REG_PUD:  rd = DATA_W'(pud_reg);
                REG_LEV:  rd = half_of(prev_reg, dec.hi);
                REG_EDS:  rd = half_of(status_reg, dec.hi);
                REG_REN:  rd = half_of(ren_reg, dec.hi);
                REG_FEN:  rd = half_of(fen_reg, dec.hi);
                REG_HEN:  rd = half_of(hen_reg, dec.hi);
                REG_LEN:  rd = half_of(len_reg, dec.hi);
                default:  rd = '0;
            endcase
        end
    end

    // Pin outputs, taken after the update
    always_comb begin
        for (int p = 0; p < NUM_PINS; p++) begin
            en[p] = (fsel_next[p * FSEL_W +: FSEL_W] == FSEL_OUTPUT);
            up[p] = (pull_next[p * PULL_W +: PULL_W] == PULL_UP);
            dn[p] = (pull_next[p * PULL_W +: PULL_W] == PULL_DOWN);
        end
        result.read_data      = rd;
        result.drive_levels   = to_out(latch_next);
        result.drive_enables  = to_out(en);
        result.pull_up_mask   = to_out(up);
        result.pull_down_mask = to_out(dn);
        result.event_pending  = |status_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsel_reg   <= '0;
            latch_reg  <= '0;
            status_reg <= '0;
            ren_reg    <= '0;
            fen_reg    <= '0;
            hen_reg    <= '0;
            len_reg    <= '0;
            prev_reg   <= '0;
            pud_reg    <= '0;
            pull_reg   <= '0;
        end else if (step) begin
            fsel_reg   <= fsel_next;
            latch_reg  <= latch_next;
            status_reg <= status_next;
            ren_reg    <= ren_next;
            fen_reg    <= fen_next;
            hen_reg    <= hen_next;
            len_reg    <= len_next;
            prev_reg   <= prev_next;
            pud_reg    <= pud_next;
            pull_reg   <= pull_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gpio_controller_event_detect.sv
`timescale 1ns / 1ps
`default_nettype none

// GPIO register block with edge and level event detection. Each input
// transfer is a bus read, a bus write or a pin sample tick (s_tuser), and
// each one yields exactly one result transfer carrying the read word and
// the pin drive, pull and event summary as they stand after that action.
// The block takes one transfer per clock while the result side is not
// stalled: an input register feeds a single pass of decode and update
// logic into a result register, and a stalled result side backs up
// through the two registers before s_tready drops.
// NUM_PINS sets how many pins hold state; result vectors are 54 bits wide.

module gpio_controller_event_detect #(
    parameter int NUM_PINS = 54
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // action
    input  wire logic [gced_pkg::S_TUSER_W-1:0]   s_tuser,
    // word_index[5:0], write_data[37:6], pin_levels[91:38], zero[95:92]
    input  wire logic [gced_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // read_data[31:0], drive_levels[85:32], drive_enables[139:86],
    // pull_up_mask[193:140], pull_down_mask[247:194], event_pending[248],
    // zero[255:249]
    output logic [gced_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready
);
    import gced_pkg::*;

    cmd_t in_reg;
    logic in_valid_reg;
    res_t out_reg;
    logic out_valid_reg;
    res_t result;
    logic advance;

    // Pipeline flow
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    gced_regfile #(
        .NUM_PINS (NUM_PINS)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cmd     (in_reg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.action     <= s_tuser[ACT_W-1:0];
            in_reg.word_index <= s_tdata[WORD_W-1:0];
            in_reg.write_data <= s_tdata[WORD_W +: DATA_W];
            in_reg.pin_levels <= s_tdata[WORD_W + DATA_W +: OUT_W];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0,
                       out_reg.event_pending,
                       out_reg.pull_down_mask,
                       out_reg.pull_up_mask,
                       out_reg.drive_enables,
                       out_reg.drive_levels,
                       out_reg.read_data};

endmodule

`default_nettype wire

FILE: hw/rtl/gced_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gced_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic [gced_pkg::S_TUSER_W-1:0]   s_tuser,
    input wire logic [gced_pkg::S_TDATA_W-1:0]   s_tdata,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [gced_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready
);
    import gced_pkg::*;

    // Reset empties the result side
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled input transfer holds
    a_in_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("stalled input changed");

    // A stalled result transfer holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Padding above event_pending stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:249] == '0)
        else $error("result padding not zero");

    // A pin is never pulled both ways
    a_pull_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[193:140] & m_tdata[247:194]) == '0)
        else $error("pin in both pull masks");

endmodule

bind gpio_controller_event_detect gced_checker u_gced_checker (.*);

`default_nettype wire
